// File: rtl/ptwt_pkg.sv
`timescale 1ns / 1ps

package ptwt_pkg;

	localparam int IDX_W = 9;
	localparam int ENTRIES_PER_TABLE = 1 << IDX_W;
	localparam int PA_W = 52;
	localparam int VA_W = 48;
	localparam int PTE_W_ = 64;

	localparam int BIT_P = 0;
	localparam int BIT_W = 1;
	localparam int BIT_U = 2;
	localparam int BIT_PS = 7;
	localparam int BIT_NX = 63;

	typedef enum logic [1:0] {
		FN_WRITE = 2'd0,
		FN_XLATE = 2'd1,
		FN_UNMAP = 2'd2,
		FN_NONE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		LVL_PML4 = 2'd0,
		LVL_PDPT = 2'd1,
		LVL_PD   = 2'd2,
		LVL_PT   = 2'd3
	} level_t;

	localparam logic [1:0] PS_4K = 2'd0;
	localparam logic [1:0] PS_2M = 2'd1;
	localparam logic [1:0] PS_1G = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} mem_ctl_t;

	typedef struct packed {
		logic            ok;
		logic [PA_W-1:0] phys_addr;
		logic            writable;
		logic            user;
		logic            no_execute;
		logic [1:0]      page_size;
	} walk_res_t;

	// Word of entry idx in the table whose address sits in bits 51..12 of tbl.
	// The caller keeps as many low bits as the memory has address bits.
	function automatic logic [PA_W-12+IDX_W-1:0] tbl_word(input logic [PTE_W_-1:0] tbl,
			input logic [IDX_W-1:0] idx);
		return {tbl[PA_W-1:12], idx};
	endfunction

endpackage

// File: rtl/ptwt_seq.sv
`timescale 1ns / 1ps

module ptwt_seq
	import ptwt_pkg::*;
#(
	parameter int AW = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          func,
	input  logic [PA_W-1:0]     root_addr,
	input  logic [VA_W-1:0]     virt_addr,
	input  logic [11:0]         entry_index,
	input  logic [PTE_W_-1:0]   entry_value,
	input  logic [PA_W-1:0]     default_root,
	input  logic [PTE_W_-1:0]   rdata,
	input  logic                out_free,
	output logic                busy,
	output mem_ctl_t            mem_ctl,
	output logic [AW-1:0]       mem_addr,
	output logic [PTE_W_-1:0]   mem_wdata,
	output logic                res_load,
	output walk_res_t           res
);

	state_t                state_q, state_d;
	func_t                 func_q, func_d;
	logic [VA_W-1:0]       va_q, va_d;
	level_t                level_q, level_d;
	logic                  acc_w_q, acc_w_d;
	logic                  acc_u_q, acc_u_d;
	logic [AW-1:0]         addr_q, addr_d;
	walk_res_t             res_q, res_d;

	logic [PA_W-1:0]            root_sel;
	logic [AW+11:0]             idx_ext;
	logic [PA_W-12+IDX_W-1:0]   word;
	logic [IDX_W-1:0]           nidx;
	logic                       nw, nu;

	assign root_sel = (root_addr == '0) ? default_root : root_addr;
	assign idx_ext = {{AW{1'b0}}, entry_index};
	assign busy = (state_q != ST_IDLE);
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		func_q  <= func_d;
		va_q    <= va_d;
		level_q <= level_d;
		acc_w_q <= acc_w_d;
		acc_u_q <= acc_u_d;
		addr_q  <= addr_d;
		res_q   <= res_d;
	end

	always_comb begin
		state_d   = state_q;
		func_d    = func_q;
		va_d      = va_q;
		level_d   = level_q;
		acc_w_d   = acc_w_q;
		acc_u_d   = acc_u_q;
		addr_d    = addr_q;
		res_d     = res_q;
		mem_ctl   = '0;
		mem_addr  = addr_q;
		mem_wdata = '0;
		res_load  = 1'b0;
		word      = '0;
		nw        = acc_w_q & rdata[BIT_W];
		nu        = acc_u_q & rdata[BIT_U];
		case (level_q)
			LVL_PML4: nidx = va_q[38:30];
			LVL_PDPT: nidx = va_q[29:21];
			default:  nidx = va_q[20:12];
		endcase
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					func_d  = func_t'(func);
					va_d    = virt_addr;
					level_d = LVL_PML4;
					acc_w_d = 1'b1;
					acc_u_d = 1'b1;
					res_d   = '0;
					state_d = ST_FIN;
					if (func == FN_WRITE) begin
						mem_ctl.wr = 1'b1;
						mem_addr   = idx_ext[AW-1:0];
						mem_wdata  = entry_value;
						res_d.ok   = 1'b1;
					end else if (func inside {FN_XLATE, FN_UNMAP}) begin
						word       = tbl_word({12'b0, root_sel}, virt_addr[47:39]);
						mem_ctl.rd = 1'b1;
						mem_addr   = word[AW-1:0];
						addr_d     = word[AW-1:0];
						state_d    = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				state_d = ST_FIN;
				if (!rdata[BIT_P]) begin
					res_d = '0;
				end else if (level_q == LVL_PT) begin
					if (func_q == FN_UNMAP) begin
						mem_ctl.wr = 1'b1;
						mem_addr   = addr_q;
						res_d.ok   = 1'b1;
					end else begin
						res_d.ok         = 1'b1;
						res_d.phys_addr  = {rdata[PA_W-1:12], va_q[11:0]};
						res_d.writable   = nw;
						res_d.user       = nu;
						res_d.no_execute = rdata[BIT_NX];
						res_d.page_size  = PS_4K;
					end
				end else if (rdata[BIT_PS] && level_q != LVL_PML4) begin
					if (func_q == FN_XLATE) begin
						res_d.ok         = 1'b1;
						res_d.writable   = nw;
						res_d.user       = nu;
						res_d.no_execute = rdata[BIT_NX];
						if (level_q == LVL_PDPT) begin
							res_d.phys_addr = {rdata[PA_W-1:30], va_q[29:0]};
							res_d.page_size = PS_1G;
						end else begin
							res_d.phys_addr = {rdata[PA_W-1:21], va_q[20:0]};
							res_d.page_size = PS_2M;
						end
					end
				end else begin
					word       = tbl_word(rdata, nidx);
					mem_ctl.rd = 1'b1;
					mem_addr   = word[AW-1:0];
					addr_d     = word[AW-1:0];
					level_d    = level_t'(level_q + 2'd1);
					acc_w_d    = nw;
					acc_u_d    = nu;
					state_d    = ST_WALK;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: rtl/page_table_walk_translate.sv
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// req       req_valid / req_stall  func, root_addr, virt_addr, entry_index, entry_value
// rsp       rsp_valid / rsp_stall  ok, phys_addr, writable, user, no_execute, page_size
// cfg       cfg_valid / cfg_ready  cfg_data (default root table address)
//
// A write item reads no table entry; a translate or unmap reads one entry per level, from one to four.
// The reads follow one another on the single table memory port, since each entry points to the next table.
// One item is in work at a time; req_stall is high from acceptance until the result is
// loaded into the output register, which may still hold the previous result.
// Reset clears control state and the default root; the table memory is not cleared.
// MEM_WORDS must be a power of two.

module page_table_walk_translate
	import ptwt_pkg::*;
#(
	parameter int MEM_WORDS = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [1:0]          func,
	input  logic [PA_W-1:0]     root_addr,
	input  logic [VA_W-1:0]     virt_addr,
	input  logic [11:0]         entry_index,
	input  logic [PTE_W_-1:0]   entry_value,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic                ok,
	output logic [PA_W-1:0]     phys_addr,
	output logic                writable,
	output logic                user,
	output logic                no_execute,
	output logic [1:0]          page_size,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [PA_W-1:0]     cfg_data
);

	localparam int AW = $clog2(MEM_WORDS);

	logic [PTE_W_-1:0]   mem [MEM_WORDS];
	logic [PTE_W_-1:0]   rdata_q;
	logic [PA_W-1:0]     default_root_q;
	logic                rsp_valid_q;
	walk_res_t           rsp_q;

	logic                busy;
	logic                start;
	logic                out_free;
	logic                res_load;
	mem_ctl_t            mem_ctl;
	logic [AW-1:0]       mem_addr;
	logic [PTE_W_-1:0]   mem_wdata;
	walk_res_t           res;

	assign cfg_ready = 1'b1;
	assign req_stall = busy;
	assign start = req_valid && !busy;
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_root_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			default_root_q <= cfg_data;
		end
	end

	ptwt_seq #(
		.AW(AW)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.func         (func),
		.root_addr    (root_addr),
		.virt_addr    (virt_addr),
		.entry_index  (entry_index),
		.entry_value  (entry_value),
		.default_root (default_root_q),
		.rdata        (rdata_q),
		.out_free     (out_free),
		.busy         (busy),
		.mem_ctl      (mem_ctl),
		.mem_addr     (mem_addr),
		.mem_wdata    (mem_wdata),
		.res_load     (res_load),
		.res          (res)
	);

	always_ff @(posedge clk) begin
		if (mem_ctl.wr) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_ctl.rd) begin
			rdata_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign ok         = rsp_q.ok;
	assign phys_addr  = rsp_q.phys_addr;
	assign writable   = rsp_q.writable;
	assign user       = rsp_q.user;
	assign no_execute = rsp_q.no_execute;
	assign page_size  = rsp_q.page_size;

endmodule

// File: rtl/ptwt_check.sv
`timescale 1ns / 1ps

module ptwt_check
	import ptwt_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input logic                ok,
	input logic [PA_W-1:0]     phys_addr,
	input logic                writable,
	input logic                user,
	input logic                no_execute,
	input logic [1:0]          page_size
);

	// A held result stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("result item dropped while stalled");

	// The walker takes one item at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request side not stalled after an item was accepted");

	// A failed item reports nothing but the failure.
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !ok |-> phys_addr == '0 && !writable && !user && !no_execute
			&& page_size == PS_4K)
		else $error("failed result carries nonzero fields");

	// Only the three page sizes exist.
	a_page_size: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> page_size == PS_4K || page_size == PS_2M || page_size == PS_1G)
		else $error("illegal page size code");

endmodule

bind page_table_walk_translate ptwt_check u_ptwt_check (.*);

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
	import ptwt_pkg::*;

	localparam int MEM_WORDS = 4096;
	localparam int IDLE_LIMIT = 500;
	localparam int ITEMS_PER_PHASE = 400;

	class page_walk_board;
		logic [63:0]      table_mem [MEM_WORDS];
		bit               written [MEM_WORDS];
		logic [PA_W-1:0]  default_root = '0;
		walk_res_t        pending_results [$];
		int unsigned      errors = 0;

		function void flag(string msg);
			errors++;
			if (errors <= 10) begin
				$display("%s", msg);
			end
		endfunction

		// Walks the tables as the block does. Returns 0 with the word in hole when the
		// walk would read a word that has never been written.
		function bit walk_tables(input logic [1:0] f, input logic [PA_W-1:0] root_in,
				input logic [VA_W-1:0] va, input bit commit, output walk_res_t res,
				output logic [11:0] hole);
			logic [PA_W-1:0] tbl;
			logic [63:0]     e;
			logic [1:0]      acc;
			logic [11:0]     w;
			res = '0;
			hole = '0;
			acc = '0;
			tbl = (root_in == '0) ? default_root : root_in;
			for (int lvl = 0; lvl < 4; lvl++) begin
				w = 12'(({tbl[PA_W-1:12], 9'b0} + va[47 - 9*lvl -: 9]) % MEM_WORDS);
				if (!written[w]) begin
					hole = w;
					return 1'b0;
				end
				e = table_mem[w];
				if (!e[BIT_P]) begin
					return 1'b1;
				end
				acc = (lvl == 0) ? e[BIT_U:BIT_W] : (acc & e[BIT_U:BIT_W]);
				if ((lvl == 1 || lvl == 2) && e[BIT_PS]) begin
					if (f == FN_XLATE) begin
						res.ok = 1'b1;
						res.writable = acc[0];
						res.user = acc[1];
						res.no_execute = e[BIT_NX];
						if (lvl == 1) begin
							res.phys_addr = {e[51:30], va[29:0]};
							res.page_size = PS_1G;
						end else begin
							res.phys_addr = {e[51:21], va[20:0]};
							res.page_size = PS_2M;
						end
					end
					return 1'b1;
				end
				if (lvl == 3) begin
					res.ok = 1'b1;
					if (f == FN_UNMAP) begin
						if (commit) begin
							table_mem[w] = '0;
						end
					end else begin
						res.phys_addr = {e[51:12], va[11:0]};
						res.writable = acc[0];
						res.user = acc[1];
						res.no_execute = e[BIT_NX];
						res.page_size = PS_4K;
					end
				end
				tbl = e[PA_W-1:0];
			end
			return 1'b1;
		endfunction

		function void note_item(input logic [1:0] f, input logic [PA_W-1:0] root,
				input logic [VA_W-1:0] va, input logic [11:0] idx, input logic [63:0] val);
			walk_res_t   res;
			logic [11:0] hole;
			res = '0;
			if (f == FN_WRITE) begin
				table_mem[idx] = val;
				written[idx] = 1'b1;
				res.ok = 1'b1;
			end else if (f != FN_NONE) begin
				void'(walk_tables(f, root, va, 1'b1, res, hole));
			end
			pending_results.push_back(res);
		endfunction

		function void check_result(input walk_res_t got);
			walk_res_t want;
			if (pending_results.size() == 0) begin
				flag($sformatf("Result with no item outstanding: ok=%0d pa=%h", got.ok,
						got.phys_addr));
				return;
			end
			want = pending_results.pop_front();
			if (got !== want) begin
				flag($sformatf({"Mismatch: expected ok=%0d pa=%h w=%0d u=%0d nx=%0d ps=%0d,",
						" actual ok=%0d pa=%h w=%0d u=%0d nx=%0d ps=%0d"},
						want.ok, want.phys_addr, want.writable, want.user, want.no_execute,
						want.page_size, got.ok, got.phys_addr, got.writable, got.user,
						got.no_execute, got.page_size));
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	logic [1:0]        func = '0;
	logic [PA_W-1:0]   root_addr = '0;
	logic [VA_W-1:0]   virt_addr = '0;
	logic [11:0]       entry_index = '0;
	logic [PTE_W_-1:0] entry_value = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	logic              ok;
	logic [PA_W-1:0]   phys_addr;
	logic              writable;
	logic              user;
	logic              no_execute;
	logic [1:0]        page_size;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [PA_W-1:0]   cfg_data = '0;

	page_walk_board    sb = new();
	bit                quiet = 1'b0;
	int unsigned       items_sent = 0;
	int unsigned       rsp_hold = 0;
	int unsigned       idle_cycles = 0;
	logic [VA_W-1:0]   va_pool [$];

	page_table_walk_translate #(
		.MEM_WORDS(MEM_WORDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.func(func),
		.root_addr(root_addr),
		.virt_addr(virt_addr),
		.entry_index(entry_index),
		.entry_value(entry_value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.ok(ok),
		.phys_addr(phys_addr),
		.writable(writable),
		.user(user),
		.no_execute(no_execute),
		.page_size(page_size),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Each result is held off for a freshly drawn number of cycles while it is valid.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			sb.check_result({ok, phys_addr, writable, user, no_execute, page_size});
			rsp_hold = quiet ? 0 : $urandom_range(0, 11);
		end else if (rsp_valid && rsp_hold != 0) begin
			rsp_hold--;
		end
		rsp_stall <= (rsp_hold != 0);
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
	end

	function automatic logic [63:0] rand_entry();
		logic [63:0] e;
		e = {$urandom, $urandom};
		e[BIT_P] = ($urandom_range(0, 9) < 8);
		e[BIT_PS] = ($urandom_range(0, 4) == 0);
		return e;
	endfunction

	function automatic logic [VA_W-1:0] va_of(input int l4, input int l3, input int l2,
			input int l1, input int off);
		return {9'(l4), 9'(l3), 9'(l2), 9'(l1), 12'(off)};
	endfunction

	task automatic send_req(input logic [1:0] f, input logic [PA_W-1:0] root,
			input logic [VA_W-1:0] va, input logic [11:0] idx, input logic [63:0] val);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		func <= f;
		root_addr <= root;
		virt_addr <= va;
		entry_index <= idx;
		entry_value <= val;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note_item(f, root, va, idx, val);
		items_sent++;
	endtask

	// Fills every never-written word the walk would touch, then sends the walk itself.
	task automatic send_walk(input logic [1:0] f, input logic [PA_W-1:0] root,
			input logic [VA_W-1:0] va);
		walk_res_t   scratch;
		logic [11:0] hole;
		while (!sb.walk_tables(f, root, va, 1'b0, scratch, hole)) begin
			send_req(FN_WRITE, PA_W'({$urandom, $urandom}), VA_W'({$urandom, $urandom}),
					hole, rand_entry());
		end
		send_req(f, root, va, 12'($urandom), {$urandom, $urandom});
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_root(input logic [PA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.default_root = value;
	endtask

	task automatic random_item();
		int unsigned     pick;
		logic [1:0]      f;
		logic [PA_W-1:0] root;
		logic [VA_W-1:0] va;
		pick = $urandom_range(0, 99);
		if (pick < 22) begin
			send_req(FN_WRITE, PA_W'({$urandom, $urandom}), VA_W'({$urandom, $urandom}),
					12'($urandom), rand_entry());
		end else if (pick < 26) begin
			send_req(FN_NONE, PA_W'({$urandom, $urandom}), VA_W'({$urandom, $urandom}),
					12'($urandom), {$urandom, $urandom});
		end else begin
			f = (pick < 78) ? FN_XLATE : FN_UNMAP;
			root = ($urandom_range(0, 3) == 0) ? '0 : PA_W'({$urandom, $urandom});
			if (va_pool.size() != 0 && $urandom_range(0, 1) == 0) begin
				va = va_pool[$urandom_range(0, va_pool.size() - 1)];
				va[11:0] = 12'($urandom);
				if ($urandom_range(0, 3) == 0) begin
					va[20:12] = 9'($urandom);
				end
			end else begin
				va = VA_W'({$urandom, $urandom});
				va_pool.push_back(va);
				if (va_pool.size() > 32) begin
					void'(va_pool.pop_front());
				end
			end
			send_walk(f, root, va);
		end
	endtask

	initial begin
		logic [PA_W-1:0] phase_roots [4];
		int unsigned     target;
		phase_roots[0] = 52'hF_FFFF_FFFF_F000;
		phase_roots[1] = '0;
		phase_roots[2] = PA_W'({$urandom, $urandom}) & 52'hF_FFFF_FFFF_F000;
		phase_roots[3] = PA_W'({$urandom, $urandom}) & 52'hF_FFFF_FFFF_F000;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The default root is still at its reset value of zero here.
		send_req(FN_WRITE, '0, '0, 12'd0, 64'd0);
		send_walk(FN_XLATE, '0, '0);
		settle();
		write_root(52'h1000);

		send_req(FN_WRITE, '0, '0, 12'd513, 64'h0000_0000_0000_2007);
		send_req(FN_WRITE, '0, '0, 12'd1026, 64'h0000_0000_0000_3007);
		send_req(FN_WRITE, '0, '0, 12'd1539, 64'h0000_0000_0000_4007);
		send_req(FN_WRITE, '0, '0, 12'd2052, 64'h800F_FFFF_FFFF_F007);
		send_walk(FN_XLATE, '0, va_of(1, 2, 3, 4, 'hFFF));
		send_walk(FN_XLATE, 52'h1ABC, va_of(1, 2, 3, 4, 'h5A5));
		send_req(FN_WRITE, '0, '0, 12'd1029, 64'h000F_FFFF_C000_0083);
		send_walk(FN_XLATE, '0, va_of(1, 5, 'h1FF, 'h1FF, 'hFFF));
		send_req(FN_WRITE, '0, '0, 12'd1542, 64'h8000_0000_0060_0085);
		send_walk(FN_XLATE, '0, va_of(1, 2, 6, 'h1FF, 'hFFF));
		send_req(FN_WRITE, '0, '0, 12'd1031, 64'd0);
		send_walk(FN_XLATE, '0, va_of(1, 7, 0, 0, 0));
		send_walk(FN_UNMAP, '0, va_of(1, 5, 0, 0, 0));
		send_walk(FN_UNMAP, '0, va_of(1, 2, 6, 0, 0));
		send_walk(FN_UNMAP, '0, va_of(1, 7, 0, 0, 0));
		send_walk(FN_UNMAP, '0, va_of(1, 2, 3, 4, 0));
		send_walk(FN_XLATE, '0, va_of(1, 2, 3, 4, 0));
		send_req(FN_NONE, '1, '1, '1, '1);
		send_req(FN_WRITE, '1, '1, 12'd4095, '1);
		send_walk(FN_XLATE, '1, '1);

		for (int phase = 0; phase < 4; phase++) begin
			settle();
			write_root(phase_roots[phase]);
			target = items_sent + ITEMS_PER_PHASE;
			while (items_sent < target) begin
				if (items_sent % 50 == 0) begin
					quiet = ($urandom_range(0, 5) == 0);
				end
				random_item();
			end
		end

		settle();
		if (sb.pending_results.size() != 0) begin
			sb.flag($sformatf("%0d results never arrived", sb.pending_results.size()));
		end
		if (sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
